// ===== hw/rtl/rcft_pkg.sv =====
// Package with the shared constants, action codes and result type of the range encoder.
package rcft_pkg;

    localparam int ALPHABET_SIZE_DEF = 256;
    localparam int FREQ_W            = 16;
    localparam int NUM_OUT           = 5;

    localparam logic [31:0] RC_TOP   = 32'h0100_0000;
    localparam logic [31:0] RC_THRES = 32'hFF00_0000;
    localparam logic [31:0] RC_FULL  = 32'hFFFF_FFFF;

    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_ENCODE = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;
    localparam logic [1:0] ACT_START  = 2'd3;

    typedef struct packed {
        logic [7:0]  head_byte;
        logic [31:0] run_count;
        logic [7:0]  run_byte;
        logic        error;
    } t_res;

endpackage

// ===== hw/rtl/rcft_freq_mem.sv =====
// Frequency table memory with one write port and one registered read port.
module rcft_freq_mem
    import rcft_pkg::*;
#(
    parameter int DEPTH = ALPHABET_SIZE_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [FREQ_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [FREQ_W-1:0] o_rdata
);

    logic [FREQ_W-1:0] r_mem [DEPTH];
    logic [FREQ_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rcft_divider.sv =====
// Iterative restoring divider that produces one quotient bit per cycle.
module rcft_divider
    import rcft_pkg::*;
#(
    parameter int DVS_W = 24,
    localparam int DVD_W = 32 + DVS_W,
    localparam int CW    = $clog2(DVD_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_dvd;
    logic [31:0]      r_quo;
    logic [DVS_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_dvd  <= i_dividend;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? DVS_W'(w_trial - {1'b0, r_dvs}) : DVS_W'(w_trial);
                r_quo <= {r_quo[30:0], w_ge};
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== hw/rtl/range_encoder_freq_table_top.sv =====
// Range encoder top level: sequencer, table sweep, narrowing and byte renormalisation.
// After reset a clearing pass writes zero to every table entry, one per cycle, and no item
// is taken while it runs.
// Set and start complete in the idle state; finish shifts out the remaining bytes and can be held by output stalls.
// Encode runs the table sweep through the single read port and the two passes of the bit-serial divider.
// One item is in flight at a time; results leave through an output register.
module range_encoder_freq_table_top
    import rcft_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_symbol,
    input  logic [15:0] i_count_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_head_byte,
    output logic [31:0] o_run_count,
    output logic [7:0]  o_run_byte,
    output logic        o_error,
    output logic        o_is_last
);

    localparam int AW  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int SW  = (AW + 1 > 8) ? AW + 1 : 8;
    localparam int TW  = FREQ_W + AW;
    localparam int DW  = 32 + TW;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_DIVF  = 4'd4;
    localparam logic [3:0] S_DIVC  = 4'd5;
    localparam logic [3:0] S_SHIFT = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]        r_state;
    logic [AW:0]       r_addr;
    logic              r_rd_valid;
    logic [AW-1:0]     r_rd_idx;
    logic [7:0]        r_sym;
    logic              r_finish;
    logic [2:0]        r_steps;
    logic [TW-1:0]     r_cum;
    logic [TW-1:0]     r_tot;
    logic [FREQ_W-1:0] r_f;
    logic [DW-1:0]     r_prod;
    logic              r_div_start;
    logic [31:0]       r_nr;
    logic [31:0]       r_range;
    logic [31:0]       r_low;
    logic              r_carry;
    logic [7:0]        r_cache;
    logic [31:0]       r_pending;
    logic              r_stg_valid;
    t_res              r_stg;
    logic              r_out_valid;
    t_res              r_out;
    logic              r_out_last;

    logic              w_accept;
    logic              w_sym_ok;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [FREQ_W-1:0] w_wdata;
    logic              w_re;
    logic [FREQ_W-1:0] w_rdata;
    logic              w_div_done;
    logic [31:0]       w_quot;
    logic              w_out_free;
    logic              w_emit;
    logic              w_step;
    logic [32:0]       w_sum;
    t_res              w_res;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_sym_ok   = (SW'(i_symbol) < SW'(ALPHABET_SIZE));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = (r_low < RC_THRES) || r_carry;
    assign w_step     = r_finish ? (r_steps != 3'd0)
                                 : ((r_range < RC_TOP) && (r_steps != 3'(NUM_OUT)));
    assign w_sum      = {1'b0, r_low} + {1'b0, w_quot};

    assign w_res.head_byte = r_cache + {7'd0, r_carry};
    assign w_res.run_count = r_pending;
    assign w_res.run_byte  = r_carry ? 8'h00 : 8'hFF;
    assign w_res.error     = 1'b0;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr[AW-1:0];
        w_wdata = '0;
        if (r_state == S_CLR) begin
            w_we = 1'b1;
        end else if (w_accept && i_action == ACT_SET && w_sym_ok) begin
            w_we    = 1'b1;
            w_waddr = AW'(i_symbol);
            w_wdata = i_count_value;
        end
    end

    assign w_re = (r_state == S_SCAN) && (r_addr < (AW+1)'(ALPHABET_SIZE));

    rcft_freq_mem #(.DEPTH(ALPHABET_SIZE)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    rcft_divider #(.DVS_W(TW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_tot),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_rd_valid  <= 1'b0;
            r_div_start <= 1'b0;
            r_range     <= RC_FULL;
            r_low       <= '0;
            r_carry     <= 1'b0;
            r_cache     <= '0;
            r_pending   <= '0;
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid  <= w_re;
            r_rd_idx    <= r_addr[AW-1:0];
            r_div_start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_addr <= r_addr + (AW+1)'(1);
                    if (r_addr == (AW+1)'(ALPHABET_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_sym    <= i_symbol;
                        r_steps  <= '0;
                        r_finish <= 1'b0;
                        case (i_action)
                            ACT_START: begin
                                r_range   <= RC_FULL;
                                r_low     <= '0;
                                r_carry   <= 1'b0;
                                r_cache   <= '0;
                                r_pending <= '0;
                            end
                            ACT_FINISH: begin
                                r_finish <= 1'b1;
                                r_steps  <= 3'(NUM_OUT);
                                r_state  <= S_SHIFT;
                            end
                            ACT_ENCODE: begin
                                if (w_sym_ok) begin
                                    r_addr  <= '0;
                                    r_cum   <= '0;
                                    r_tot   <= '0;
                                    r_f     <= '0;
                                    r_state <= S_SCAN;
                                end else begin
                                    r_stg       <= '{8'd0, 32'd0, 8'd0, 1'b1};
                                    r_stg_valid <= 1'b1;
                                    r_state     <= S_DONE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_re) begin
                        r_addr <= r_addr + (AW+1)'(1);
                    end
                    if (r_rd_valid) begin
                        r_tot <= r_tot + TW'(w_rdata);
                        if (SW'(r_rd_idx) < SW'(r_sym)) begin
                            r_cum <= r_cum + TW'(w_rdata);
                        end
                        if (SW'(r_rd_idx) == SW'(r_sym)) begin
                            r_f <= w_rdata;
                        end
                        if (r_rd_idx == AW'(ALPHABET_SIZE - 1)) begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    if (r_f == '0) begin
                        r_stg       <= '{8'd0, 32'd0, 8'd0, 1'b1};
                        r_stg_valid <= 1'b1;
                        r_state     <= S_DONE;
                    end else begin
                        r_prod      <= DW'(r_range) * DW'(r_f);
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVF;
                    end
                end
                S_DIVF: begin
                    if (w_div_done) begin
                        if (w_quot == '0) begin
                            r_stg       <= '{8'd0, 32'd0, 8'd0, 1'b1};
                            r_stg_valid <= 1'b1;
                            r_state     <= S_DONE;
                        end else begin
                            r_nr        <= w_quot;
                            r_prod      <= DW'(r_range) * DW'(r_cum);
                            r_div_start <= 1'b1;
                            r_state     <= S_DIVC;
                        end
                    end
                end
                S_DIVC: begin
                    if (w_div_done) begin
                        r_low   <= w_sum[31:0];
                        if (w_sum[32]) begin
                            r_carry <= 1'b1;
                        end
                        r_range <= r_nr;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (!w_step) begin
                        r_state <= S_DONE;
                    end else if (!(w_emit && r_stg_valid && !w_out_free)) begin
                        if (w_emit) begin
                            if (r_stg_valid) begin
                                r_out       <= r_stg;
                                r_out_last  <= 1'b0;
                                r_out_valid <= 1'b1;
                            end
                            r_stg       <= w_res;
                            r_stg_valid <= 1'b1;
                            r_pending   <= '0;
                            r_cache     <= r_low[31:24];
                            r_carry     <= 1'b0;
                        end else begin
                            r_pending <= r_pending + 32'd1;
                        end
                        r_low <= r_low << 8;
                        if (r_finish) begin
                            r_steps <= r_steps - 3'd1;
                        end else begin
                            r_range <= r_range << 8;
                            if (w_emit) begin
                                r_steps <= r_steps + 3'd1;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (!r_stg_valid) begin
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out       <= r_stg;
                        r_out_last  <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_stg_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_head_byte = r_out.head_byte;
    assign o_run_count = r_out.run_count;
    assign o_run_byte  = r_out.run_byte;
    assign o_error     = r_out.error;
    assign o_is_last   = r_out_last;

endmodule

// ===== hw/rtl/rcft_checker.sv =====
// Port-level checker for the range encoder and its bind to the top level.
module rcft_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_action,
    input logic [7:0]  i_symbol,
    input logic [15:0] i_count_value,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_head_byte,
    input logic [31:0] o_run_count,
    input logic [7:0]  o_run_byte,
    input logic        o_error,
    input logic        o_is_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Output transfer withdrawn before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_head_byte) && $stable(o_run_count)
            && $stable(o_run_byte) && $stable(o_is_last))
        else $error("Output payload changed while stalled.");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_is_last && o_head_byte == 8'd0
            && o_run_count == 32'd0 && o_run_byte == 8'd0)
        else $error("Refused encode result is malformed.");

    a_run_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_error |-> o_run_byte == 8'h00 || o_run_byte == 8'hFF)
        else $error("Run byte is neither zero nor all ones.");

    a_clear_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_in_ready && !o_out_valid)
        else $error("Block takes items during the clearing pass.");

endmodule

bind range_encoder_freq_table_top rcft_assertions u_rcft_assertions (.*);

// ===== tb/rcft_checker.sv =====
// Checker for the range encoder: predicts byte groups from accepted items and compares results.
module rcft_checker
    import rcft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_symbol,
    input  logic [15:0] i_count_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_head_byte,
    input  logic [31:0] i_run_count,
    input  logic [7:0]  i_run_byte,
    input  logic        i_error,
    input  logic        i_is_last,
    output int          o_fail_count,
    output int          o_groups_waiting,
    output int          o_groups_seen
);

    typedef struct {
        logic [7:0]  head;
        logic [31:0] run;
        logic [7:0]  rbyte;
        logic        err;
        logic        last;
    } t_group;

    t_group      groups_expected[$];
    logic [15:0] freq_q[256];
    logic [31:0] range_q;
    logic [31:0] low_q;
    logic [31:0] pend_q;
    logic        carry_q;
    logic [7:0]  cache_q;
    int          fails;
    int          seen;

    assign o_fail_count     = fails;
    assign o_groups_waiting = groups_expected.size();
    assign o_groups_seen    = seen;

    task automatic restart_coder();
        range_q = RC_FULL;
        low_q   = '0;
        carry_q = 1'b0;
        cache_q = '0;
        pend_q  = '0;
    endtask

    task automatic shift_out_byte();
        t_group g;
        if (low_q < RC_THRES || carry_q) begin
            g.head  = cache_q + {7'd0, carry_q};
            g.run   = pend_q;
            g.rbyte = carry_q ? 8'h00 : 8'hFF;
            g.err   = 1'b0;
            g.last  = 1'b0;
            groups_expected.push_back(g);
            pend_q  = '0;
            cache_q = low_q[31:24];
            carry_q = 1'b0;
        end else begin
            pend_q = pend_q + 32'd1;
        end
        low_q = low_q << 8;
    endtask

    task automatic encode_item(input logic [1:0] act, input logic [7:0] sym,
                               input logic [15:0] val);
        int          base;
        logic [31:0] cum;
        logic [31:0] tot;
        logic [31:0] nr;
        logic [31:0] old;
        logic [63:0] q;
        t_group      g;
        base = groups_expected.size();
        case (act)
            ACT_SET: begin
                freq_q[sym] = val;
            end
            ACT_START: begin
                restart_coder();
            end
            ACT_FINISH: begin
                repeat (5) shift_out_byte();
            end
            default: begin
                cum = '0;
                tot = '0;
                for (int i = 0; i < 256; i++) begin
                    if (i < int'(sym))
                        cum += 32'(freq_q[i]);
                    tot += 32'(freq_q[i]);
                end
                nr = '0;
                if (freq_q[sym] != 0 && tot != 0) begin
                    q  = ({32'd0, range_q} * {48'd0, freq_q[sym]}) / {32'd0, tot};
                    nr = q[31:0];
                end
                if (nr == 0) begin
                    g.head  = '0;
                    g.run   = '0;
                    g.rbyte = '0;
                    g.err   = 1'b1;
                    g.last  = 1'b0;
                    groups_expected.push_back(g);
                end else begin
                    old   = low_q;
                    q     = ({32'd0, range_q} * {32'd0, cum}) / {32'd0, tot};
                    low_q = low_q + q[31:0];
                    if (low_q < old)
                        carry_q = 1'b1;
                    range_q = nr;
                    while (range_q < RC_TOP && groups_expected.size() - base < NUM_OUT) begin
                        range_q = range_q << 8;
                        shift_out_byte();
                    end
                end
            end
        endcase
        if (groups_expected.size() > base)
            groups_expected[groups_expected.size() - 1].last = 1'b1;
    endtask

    initial begin
        fails = 0;
        seen  = 0;
        foreach (freq_q[i])
            freq_q[i] = '0;
        restart_coder();
    end

    always @(posedge i_clk) begin
        t_group g;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                encode_item(i_action, i_symbol, i_count_value);
            if (i_out_valid && i_out_ready) begin
                seen++;
                if (groups_expected.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fails++;
                end else begin
                    g = groups_expected.pop_front();
                    if (i_head_byte !== g.head) begin
                        $error("head_byte expected %0h got %0h", g.head, i_head_byte);
                        fails++;
                    end
                    if (i_run_count !== g.run) begin
                        $error("run_count expected %0d got %0d", g.run, i_run_count);
                        fails++;
                    end
                    if (i_run_byte !== g.rbyte) begin
                        $error("run_byte expected %0h got %0h", g.rbyte, i_run_byte);
                        fails++;
                    end
                    if (i_error !== g.err) begin
                        $error("error expected %0b got %0b", g.err, i_error);
                        fails++;
                    end
                    if (i_is_last !== g.last) begin
                        $error("is_last expected %0b got %0b", g.last, i_is_last);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the range encoder: stimulus, output stalls, watchdog and verdict.
module tb;
    import rcft_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_action;
    logic [7:0]  i_symbol;
    logic [15:0] i_count_value;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_head_byte;
    logic [31:0] o_run_count;
    logic [7:0]  o_run_byte;
    logic        o_error;
    logic        o_is_last;

    int          fail_count;
    int          groups_waiting;
    int          groups_seen;
    int          items_sent;
    int          encodes_sent;
    int          cycle_count = 0;
    int          quiet_cycles = 0;
    logic        send_burst;
    logic [7:0]  live_syms[$];

    range_encoder_freq_table_top dut (.*);

    rcft_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_symbol        (i_symbol),
        .i_count_value   (i_count_value),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_head_byte     (o_head_byte),
        .i_run_count     (o_run_count),
        .i_run_byte      (o_run_byte),
        .i_error         (o_error),
        .i_is_last       (o_is_last),
        .o_fail_count    (fail_count),
        .o_groups_waiting(groups_waiting),
        .o_groups_seen   (groups_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver never stalls during one long window of the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= 30000 && cycle_count < 45000)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(99) >= 26);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send(input logic [1:0] act, input logic [7:0] sym, input logic [15:0] val);
        if (!send_burst && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_symbol      <= sym;
        i_count_value <= val;
        @(negedge i_clk);
        while (!o_in_ready)
            @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
        if (act == ACT_ENCODE)
            encodes_sent++;
    endtask

    task automatic set_freq(input logic [7:0] sym, input logic [15:0] val);
        send(ACT_SET, sym, val);
        if (val != 0)
            live_syms.push_back(sym);
    endtask

    initial begin
        int n;
        items_sent    = 0;
        encodes_sent  = 0;
        send_burst    = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = ACT_SET;
        i_symbol      = '0;
        i_count_value = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty table, extreme entries and values, refusals and flushes.
        send(ACT_ENCODE, 8'd5, 16'd0);
        send(ACT_FINISH, 8'd0, 16'd0);
        set_freq(8'd0, 16'hFFFF);
        set_freq(8'd255, 16'hFFFF);
        set_freq(8'd7, 16'd1);
        send(ACT_START, 8'hFF, 16'hFFFF);
        send(ACT_ENCODE, 8'd0, 16'd0);
        send(ACT_ENCODE, 8'd255, 16'hFFFF);
        send(ACT_ENCODE, 8'd7, 16'd0);
        send(ACT_ENCODE, 8'd7, 16'd0);
        send(ACT_ENCODE, 8'd3, 16'd0);
        send(ACT_FINISH, 8'd0, 16'd0);
        send(ACT_START, 8'd0, 16'd0);
        set_freq(8'd128, 16'h8000);
        send(ACT_ENCODE, 8'd255, 16'd0);
        send(ACT_ENCODE, 8'd255, 16'd0);
        send(ACT_ENCODE, 8'd7, 16'd0);
        send(ACT_FINISH, 8'd0, 16'd0);
        send(ACT_FINISH, 8'd0, 16'd0);
        send(ACT_SET, 8'd0, 16'd0);
        send(ACT_ENCODE, 8'd0, 16'd0);

        // Random part: an occasional random item; else start, a few table writes, a run of encodes, usually a flush.
        while (items_sent < 440) begin
            send_burst = (items_sent >= 200 && items_sent < 300);
            if ($urandom_range(99) < 5) begin
                send(2'($urandom_range(3)), 8'($urandom_range(255)),
                     16'($urandom_range(65535)));
                continue;
            end
            send(ACT_START, 8'($urandom_range(255)), 16'($urandom_range(65535)));
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(9) == 0)
                    set_freq(8'($urandom_range(255)), 16'd0);
                else if ($urandom_range(3) == 0)
                    set_freq(8'($urandom_range(255)), 16'($urandom_range(1, 8)));
                else
                    set_freq(8'($urandom_range(255)), 16'($urandom_range(65535)));
            end
            n = $urandom_range(5, 20);
            repeat (n) begin
                if (live_syms.size() == 0 || $urandom_range(9) == 0)
                    send(ACT_ENCODE, 8'($urandom_range(255)), 16'($urandom_range(65535)));
                else
                    send(ACT_ENCODE, live_syms[$urandom_range(live_syms.size() - 1)],
                         16'($urandom_range(65535)));
            end
            if ($urandom_range(9) < 8)
                send(ACT_FINISH, 8'($urandom_range(255)), 16'($urandom_range(65535)));
            if (live_syms.size() > 40)
                live_syms.delete();
        end
        i_in_valid <= 1'b0;

        while (groups_waiting != 0)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);

        $display("Sent %0d items, %0d of them encodes; checked %0d byte groups.",
                 items_sent, encodes_sent, groups_seen);
        if (fail_count == 0 && groups_waiting == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
